@@ rtl/tte_pkg.sv @@
package tte_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 32;
  localparam int LINE_MAX = 255;

  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int NC_W    = 7;
  localparam int NR_W    = 6;
  localparam int ADDR_W  = 11;
  localparam int DEPTH   = MAX_COLS * MAX_ROWS;
  localparam int STORE_W = $clog2(DEPTH);
  localparam int LEN_W   = $clog2(LINE_MAX + 1);
  localparam int KEY_W   = 8;
  localparam int CHAR_W  = 7;
  localparam int CLR_W   = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'd1;

  localparam logic [NC_W-1:0] COLUMNS_RESET = 7'd40;
  localparam logic [NR_W-1:0] ROWS_RESET    = 6'd30;

  localparam logic [KEY_W-1:0] K_CR    = 8'h0D;
  localparam logic [KEY_W-1:0] K_BS    = 8'h08;
  localparam logic [KEY_W-1:0] K_ESC   = 8'h1B;
  localparam logic [KEY_W-1:0] K_SPACE = 8'h20;
  localparam logic [KEY_W-1:0] K_LAST  = 8'd126;

  localparam logic [CHAR_W-1:0] CH_M      = 7'h6D;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 7'h5B;
  localparam logic [CHAR_W-1:0] CH_3      = 7'h33;
  localparam logic [CHAR_W-1:0] CH_4      = 7'h34;
  localparam logic [CHAR_W-1:0] CH_0      = 7'h30;
  localparam logic [CHAR_W-1:0] CH_9      = 7'h39;

  localparam logic [CLR_W-1:0] CLR_BLACK = 3'd0;
  localparam logic [CLR_W-1:0] CLR_GREEN = 3'd2;
  localparam logic [CLR_W-1:0] CLR_WHITE = 3'd7;

  typedef enum logic [3:0] {
    ST_INIT   = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_WORK   = 4'b0100,
    ST_SCROLL = 4'b1000
  } state_t;

  typedef struct packed {
    logic init_wr;
    logic load_key;
    logic reduce;
    logic step;
    logic clear_wr;
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic top_ge_nr;
    logic scroll;
    logic clear_last;
  } status_t;

  typedef struct packed {
    logic              cell_write;
    logic [ADDR_W-1:0] cell_address;
    logic [CHAR_W-1:0] cell_char;
    logic [CLR_W-1:0]  cell_colour;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [ROW_W-1:0]  top_row;
    logic [CLR_W-1:0]  fore_index;
    logic [CLR_W-1:0]  back_index;
    logic              line_done;
  } result_t;

endpackage

@@ rtl/tte_if.sv @@
interface tte_key_if import tte_pkg::*;;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_byte;
  modport source (output valid, output key_byte, input ready);
  modport sink (input valid, input key_byte, output ready);
endinterface

interface tte_res_if import tte_pkg::*;;
  logic              valid;
  logic              ready;
  logic              cell_write;
  logic [ADDR_W-1:0] cell_address;
  logic [CHAR_W-1:0] cell_char;
  logic [CLR_W-1:0]  cell_colour;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [ROW_W-1:0]  top_row;
  logic [CLR_W-1:0]  fore_index;
  logic [CLR_W-1:0]  back_index;
  logic              line_done;
  modport source (output valid, output cell_write, output cell_address, output cell_char,
                  output cell_colour, output cursor_col, output cursor_row, output top_row,
                  output fore_index, output back_index, output line_done, input ready);
  modport sink (input valid, input cell_write, input cell_address, input cell_char,
                input cell_colour, input cursor_col, input cursor_row, input top_row,
                input fore_index, input back_index, input line_done, output ready);
endinterface

interface tte_cfg_if import tte_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/text_terminal_key_engine_core.sv @@
// Text terminal key engine.
// key: one key byte per transaction (valid/ready). Printable bytes outside
//   an escape sequence go into the character store at the cursor with the
//   current foreground colour; CR, backspace and ESC[3d / ESC[4d ... m act on
//   the cursor, line count and colour indexes.
// res: exactly one result transaction per key: the cell write (if any) and
//   the cursor, top row and colour state after the key.
// cfg: register writes (index 0 columns, index 1 rows), always ready; write
//   them only while no key is in flight.
// Flow: a taken key byte is registered; the WORK state then applies it and
//   registers the result, first taking top pointer wrap steps when the rows
//   register has shrunk below the top pointer (at most 31).
// Keys: the next key is taken only back in the idle state; a key that scrolls
//   the screen adds a row clear (one cell per cycle over the single store
//   write port) before the next key is taken.
// Reset: synchronous on rst. The whole store is then filled one cell per cycle,
//   during which key.ready stays low; cfg writes are taken.
// Stall: the result holds in its output register until res.ready; the next
//   key is taken at the earliest in the cycle that the result is consumed.
module text_terminal_key_engine_core import tte_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  tte_key_if.sink   key,
  tte_res_if.source res,
  tte_cfg_if.sink   cfg
);

  cmd_t    cmd;
  status_t status;
  result_t result;

  // configuration never stalls
  assign cfg.ready = 1'b1;

  tte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key.valid),
    .key_ready (key.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .status    (status),
    .cmd       (cmd)
  );

  tte_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .key_byte  (key.key_byte),
    .cfg_wr    (cfg.valid && cfg.ready),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .result    (result)
  );

  // drive the result payload straight from the datapath registers
  assign res.cell_write   = result.cell_write;
  assign res.cell_address = result.cell_address;
  assign res.cell_char    = result.cell_char;
  assign res.cell_colour  = result.cell_colour;
  assign res.cursor_col   = result.cursor_col;
  assign res.cursor_row   = result.cursor_row;
  assign res.top_row      = result.top_row;
  assign res.fore_index   = result.fore_index;
  assign res.back_index   = result.back_index;
  assign res.line_done    = result.line_done;

endmodule

@@ rtl/tte_ctrl.sv @@
module tte_ctrl import tte_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    key_valid,
  output logic    key_ready,
  output logic    res_valid,
  input  logic    res_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   out_valid, out_valid_next;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    cmd            = '0;
    key_ready      = 1'b0;
    if (out_valid && res_ready) out_valid_next = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.init_wr = 1'b1;
        if (status.init_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        key_ready = !out_valid || res_ready;
        if (key_valid && key_ready) begin
          cmd.load_key = 1'b1;
          state_next   = ST_WORK;
        end
      end
      ST_WORK: begin
        // wrap the top pointer into the rows in use before the key acts
        if (status.top_ge_nr) begin
          cmd.reduce = 1'b1;
        end else begin
          cmd.step       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = status.scroll ? ST_SCROLL : ST_IDLE;
        end
      end
      ST_SCROLL: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign res_valid = out_valid;

endmodule

@@ rtl/tte_dp.sv @@
module tte_dp import tte_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic [KEY_W-1:0]      key_byte,
  input  logic                  cfg_wr,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output result_t               result
);

  logic [CHAR_W-1:0] char_mem [DEPTH];
  logic [CLR_W-1:0]  colour_mem [DEPTH];

  logic [NC_W-1:0]    columns;
  logic [NR_W-1:0]    rows;
  logic [KEY_W-1:0]   key;
  logic [COL_W-1:0]   col_pos;
  logic [ROW_W-1:0]   row_pos;
  logic [ROW_W-1:0]   top_pointer;
  logic [CLR_W-1:0]   fore_colour;
  logic [CLR_W-1:0]   back_colour;
  logic [LEN_W-1:0]   line_length;
  logic               escape_open;
  logic [1:0]         escape_count;
  logic [CHAR_W-1:0]  escape_chars [3];
  logic [STORE_W-1:0] sweep;
  logic [ROW_W-1:0]   cleared_row;

  logic              cell_write;
  logic [ADDR_W-1:0] cell_address;
  logic [CHAR_W-1:0] cell_char;
  logic [CLR_W-1:0]  cell_colour;
  logic              line_done;

  logic [NC_W-1:0]   nc;
  logic [NR_W-1:0]   nr;
  logic [COL_W-1:0]  cx;
  logic [ROW_W-1:0]  cy;
  logic              md_scroll;
  logic [ROW_W-1:0]  md_y;
  logic [ROW_W-1:0]  md_top;
  logic [NR_W-1:0]   cy_inc;
  logic [NR_W-1:0]   top_inc;
  logic [NR_W-1:0]   phys_sum;
  logic [ROW_W-1:0]  phys;
  logic [NC_W-1:0]   cx_inc;
  logic [CHAR_W-1:0] key7;
  logic [CHAR_W-1:0] digit;
  logic [CLR_W-1:0]  digit_clr;
  logic              printable;

  logic [COL_W-1:0]  cx_next;
  logic [ROW_W-1:0]  cy_next;
  logic [ROW_W-1:0]  top_next;
  logic [CLR_W-1:0]  fore_next;
  logic [CLR_W-1:0]  back_next;
  logic [LEN_W-1:0]  len_next;
  logic              esc_open_next;
  logic [1:0]        esc_count_next;
  logic [CHAR_W-1:0] esc_chars_next [3];
  logic              wr_next;
  logic [ADDR_W-1:0] addr_next;
  logic              done_next;
  logic              scroll_next;

  logic              mem_we;
  logic [STORE_W-1:0] mem_addr;
  logic [CHAR_W-1:0] mem_char;
  logic [CLR_W-1:0]  mem_colour;

  always_comb begin
    if (columns == '0) nc = NC_W'(1);
    else if (columns > NC_W'(MAX_COLS)) nc = NC_W'(MAX_COLS);
    else nc = columns;
    if (rows == '0) nr = NR_W'(1);
    else if (rows > NR_W'(MAX_ROWS)) nr = NR_W'(MAX_ROWS);
    else nr = rows;
  end

  always_comb begin
    cx = ({1'b0, col_pos} >= nc) ? COL_W'(nc - NC_W'(1)) : col_pos;
    cy = ({1'b0, row_pos} >= nr) ? ROW_W'(nr - NR_W'(1)) : row_pos;

    cy_inc    = {1'b0, cy} + NR_W'(1);
    top_inc   = {1'b0, top_pointer} + NR_W'(1);
    md_scroll = cy_inc >= nr;
    md_y      = md_scroll ? ROW_W'(nr - NR_W'(1)) : cy_inc[ROW_W-1:0];
    md_top    = !md_scroll ? top_pointer :
                (top_inc >= nr) ? '0 : top_inc[ROW_W-1:0];

    phys_sum = {1'b0, top_pointer} + {1'b0, cy};
    phys     = (phys_sum >= nr) ? ROW_W'(phys_sum - nr) : phys_sum[ROW_W-1:0];
    cx_inc   = {1'b0, cx} + NC_W'(1);

    key7      = key[CHAR_W-1:0];
    printable = (key >= K_SPACE) && (key <= K_LAST);

    cx_next        = cx;
    cy_next        = cy;
    top_next       = top_pointer;
    fore_next      = fore_colour;
    back_next      = back_colour;
    len_next       = line_length;
    esc_open_next  = escape_open;
    esc_count_next = escape_count;
    esc_chars_next = escape_chars;
    wr_next        = 1'b0;
    addr_next      = '0;
    done_next      = 1'b0;
    scroll_next    = 1'b0;
    digit          = '0;
    digit_clr      = '0;

    if (key == K_CR) begin
      cx_next     = '0;
      cy_next     = md_y;
      top_next    = md_top;
      scroll_next = md_scroll;
      done_next   = 1'b1;
      len_next    = '0;
    end else if (key == K_BS) begin
      if (line_length != '0) begin
        len_next = line_length - LEN_W'(1);
        if (cx != '0) cx_next = cx - COL_W'(1);
      end
    end else if (key == K_ESC) begin
      esc_open_next  = 1'b1;
      esc_count_next = '0;
      esc_chars_next = '{default: '0};
    end else if (printable) begin
      if (escape_open) begin
        if (escape_count != 2'd3) begin
          esc_chars_next[escape_count] = key7;
          esc_count_next = escape_count + 2'd1;
        end
        if (key7 == CH_M) begin
          digit     = esc_chars_next[2] - CH_0;
          digit_clr = (digit > CHAR_W'(CLR_WHITE)) ? CLR_WHITE : digit[CLR_W-1:0];
          if (esc_count_next == 2'd3 && esc_chars_next[0] == CH_LBRACK &&
              esc_chars_next[2] >= CH_0 && esc_chars_next[2] <= CH_9) begin
            if (esc_chars_next[1] == CH_3) fore_next = digit_clr;
            else if (esc_chars_next[1] == CH_4) back_next = digit_clr;
          end
          esc_open_next  = 1'b0;
          esc_count_next = '0;
          esc_chars_next = '{default: '0};
        end
      end else begin
        wr_next   = 1'b1;
        addr_next = ADDR_W'({phys, cx});
        if (line_length != LEN_W'(LINE_MAX)) len_next = line_length + LEN_W'(1);
        if (cx_inc >= nc) begin
          cx_next     = '0;
          cy_next     = md_y;
          top_next    = md_top;
          scroll_next = md_scroll;
        end else begin
          cx_next = cx_inc[COL_W-1:0];
        end
      end
    end
  end

  assign status.init_last  = sweep == STORE_W'(DEPTH - 1);
  assign status.top_ge_nr  = {1'b0, top_pointer} >= nr;
  assign status.scroll     = scroll_next;
  assign status.clear_last = sweep[COL_W-1:0] == COL_W'(MAX_COLS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      columns      <= COLUMNS_RESET;
      rows         <= ROWS_RESET;
      col_pos      <= '0;
      row_pos      <= '0;
      top_pointer  <= '0;
      fore_colour  <= CLR_GREEN;
      back_colour  <= CLR_BLACK;
      line_length  <= '0;
      escape_open  <= 1'b0;
      escape_count <= '0;
      escape_chars <= '{default: '0};
      sweep        <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          REG_COLUMNS: columns <= cfg_data[NC_W-1:0];
          REG_ROWS:    rows    <= cfg_data[NR_W-1:0];
          default: ;
        endcase
      end
      if (cmd.reduce) top_pointer <= ROW_W'({1'b0, top_pointer} - nr);
      if (cmd.step) begin
        col_pos      <= cx_next;
        row_pos      <= cy_next;
        top_pointer  <= top_next;
        fore_colour  <= fore_next;
        back_colour  <= back_next;
        line_length  <= len_next;
        escape_open  <= esc_open_next;
        escape_count <= esc_count_next;
        escape_chars <= esc_chars_next;
        sweep        <= '0;
      end
      if (cmd.init_wr || cmd.clear_wr) sweep <= sweep + STORE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_key) key <= key_byte;
    if (cmd.step) begin
      cell_write   <= wr_next;
      cell_address <= addr_next;
      cell_char    <= wr_next ? key7 : '0;
      cell_colour  <= wr_next ? fore_colour : '0;
      line_done    <= done_next;
      cleared_row  <= top_pointer;
    end
  end

  // single write port shared by the reset fill, key writes and row clears
  always_comb begin
    mem_we     = cmd.init_wr || cmd.clear_wr || (cmd.step && wr_next);
    mem_addr   = sweep;
    mem_char   = '0;
    mem_colour = CLR_GREEN;
    if (cmd.clear_wr) begin
      mem_addr   = STORE_W'({cleared_row, sweep[COL_W-1:0]});
      mem_colour = CLR_BLACK;
    end else if (cmd.step) begin
      mem_addr   = addr_next[STORE_W-1:0];
      mem_char   = key7;
      mem_colour = fore_colour;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      char_mem[mem_addr]   <= mem_char;
      colour_mem[mem_addr] <= mem_colour;
    end
  end

  assign result.cell_write   = cell_write;
  assign result.cell_address = cell_address;
  assign result.cell_char    = cell_char;
  assign result.cell_colour  = cell_colour;
  assign result.cursor_col   = col_pos;
  assign result.cursor_row   = row_pos;
  assign result.top_row      = top_pointer;
  assign result.fore_index   = fore_colour;
  assign result.back_index   = back_colour;
  assign result.line_done    = line_done;

endmodule

@@ rtl/tte_checker.sv @@
module tte_checker import tte_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              key_valid,
  input logic              key_ready,
  input logic              res_valid,
  input logic              res_ready,
  input logic              cell_write,
  input logic [ADDR_W-1:0] cell_address,
  input logic [CHAR_W-1:0] cell_char,
  input logic [CLR_W-1:0]  cell_colour,
  input logic [COL_W-1:0]  cursor_col,
  input logic              line_done
);

  // a key is taken only when the previous result is gone or leaving
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    key_valid && key_ready |-> !res_valid || res_ready)
    else $error("key taken while a result is still pending");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !res_valid && !key_ready)
    else $error("handshake active right after reset");

  a_cr_home: assert property (@(posedge clk) disable iff (rst)
    res_valid && line_done |-> cursor_col == '0 && !cell_write)
    else $error("carriage return left cursor off column zero");

  a_printable: assert property (@(posedge clk) disable iff (rst)
    res_valid && cell_write |-> cell_char >= K_SPACE[CHAR_W-1:0] && cell_char != 7'h7F)
    else $error("non-printable character written");

  a_quiet_cell: assert property (@(posedge clk) disable iff (rst)
    res_valid && !cell_write |-> cell_address == '0 && cell_char == '0 && cell_colour == '0)
    else $error("cell fields not zero without a write");

endmodule

bind text_terminal_key_engine_core tte_checker u_tte_checker (
  .clk          (clk),
  .rst          (rst),
  .key_valid    (key.valid),
  .key_ready    (key.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .cell_write   (res.cell_write),
  .cell_address (res.cell_address),
  .cell_char    (res.cell_char),
  .cell_colour  (res.cell_colour),
  .cursor_col   (res.cursor_col),
  .line_done    (res.line_done)
);

@@ tb/tb_text_terminal_key_engine_core.sv @@
`timescale 1ns / 1ps

module tb_text_terminal_key_engine_core;
  import tte_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 9;
  // Bound on the slowest legal run (every key scrolling, long gaps on both
  // sides, the store fill after reset), with a wide margin.
  localparam int CYCLE_LIMIT  = 1_000_000;
  // Covers a row clear plus up to 31 top pointer wrap steps.
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_KEYS   = 250;
  localparam int REPORT_LIMIT  = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tte_key_if key_if ();
  tte_res_if res_if ();
  tte_cfg_if cfg_if ();

  text_terminal_key_engine_core uut (
    .clk (clk),
    .rst (rst),
    .key (key_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  always #(CLK_HALF) clk = ~clk;

  // Shared run state.
  result_t     pending_results[$];
  int unsigned fail_count = 0;
  int unsigned results_seen = 0;
  int unsigned active_keys = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_off_request = 0;
  bit          key_offered = 1'b0;
  bit          tx_gaps = 1'b1;
  bit          rx_stalls = 1'b1;

  // Terminal state as the block should hold it.
  logic [NC_W-1:0]   cols_reg = COLUMNS_RESET;
  logic [NR_W-1:0]   rows_reg = ROWS_RESET;
  int unsigned       cur_x = 0;
  int unsigned       cur_y = 0;
  int unsigned       top_ptr = 0;
  int unsigned       fg = CLR_GREEN;
  int unsigned       bg = CLR_BLACK;
  int unsigned       line_len = 0;
  bit                esc_on = 1'b0;
  int unsigned       esc_cnt = 0;
  logic [CHAR_W-1:0] esc_buf [3] = '{default: '0};

  // Most gaps are short, some are long.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit is_ignored(input logic [KEY_W-1:0] k);
    if (k == K_CR || k == K_BS || k == K_ESC) return 1'b0;
    return (k < K_SPACE) || (k > K_LAST);
  endfunction

  // Advance one row; at the bottom move the top pointer instead.
  function automatic void step_down(input int unsigned nr);
    cur_y++;
    if (cur_y >= nr) begin
      top_ptr = (top_ptr + 1) % nr;
      cur_y = nr - 1;
    end
  endfunction

  // Apply one key to the terminal state and build the result it produces.
  function automatic result_t predict_key_result(input logic [KEY_W-1:0] k);
    result_t     r;
    int unsigned nc;
    int unsigned nr;
    int unsigned phys;
    int unsigned c;
    r = '0;
    nc = (cols_reg == 0) ? 1 : ((cols_reg > MAX_COLS) ? MAX_COLS : cols_reg);
    nr = (rows_reg == 0) ? 1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg);
    // Pull the cursor back inside a screen that has shrunk.
    if (cur_x >= nc) cur_x = nc - 1;
    if (cur_y >= nr) cur_y = nr - 1;
    top_ptr = top_ptr % nr;

    if (k == K_CR) begin
      cur_x = 0;
      step_down(nr);
      r.line_done = 1'b1;
      line_len = 0;
    end else if (k == K_BS) begin
      if (line_len > 0) begin
        line_len--;
        if (cur_x > 0) cur_x--;
      end
    end else if (k == K_ESC) begin
      esc_on = 1'b1;
      esc_cnt = 0;
      esc_buf = '{default: '0};
    end else if (k >= K_SPACE && k <= K_LAST) begin
      if (esc_on) begin
        if (esc_cnt < 3) begin
          esc_buf[esc_cnt] = k[CHAR_W-1:0];
          esc_cnt++;
        end
        if (k == CH_M) begin
          if (esc_cnt >= 3 && esc_buf[0] == CH_LBRACK &&
              esc_buf[2] >= CH_0 && esc_buf[2] <= CH_9) begin
            c = int'(esc_buf[2]) - int'(CH_0);
            if (c > CLR_WHITE) c = CLR_WHITE;
            if (esc_buf[1] == CH_3) fg = c;
            else if (esc_buf[1] == CH_4) bg = c;
          end
          esc_on = 1'b0;
          esc_cnt = 0;
          esc_buf = '{default: '0};
        end
      end else begin
        phys = (top_ptr + cur_y) % nr;
        r.cell_write   = 1'b1;
        r.cell_address = ADDR_W'(phys * MAX_COLS + cur_x);
        r.cell_char    = k[CHAR_W-1:0];
        r.cell_colour  = CLR_W'(fg);
        if (line_len < LINE_MAX) line_len++;
        cur_x++;
        if (cur_x >= nc) begin
          cur_x = 0;
          step_down(nr);
        end
      end
    end

    r.cursor_col = COL_W'(cur_x);
    r.cursor_row = ROW_W'(cur_y);
    r.top_row    = ROW_W'(top_ptr);
    r.fore_index = CLR_W'(fg);
    r.back_index = CLR_W'(bg);
    return r;
  endfunction

  function automatic void report_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("[%0t] %s", $realtime, msg);
  endfunction

  function automatic void check_field(input string field, input int unsigned want_v,
                                      input int unsigned got_v);
    if (want_v != got_v)
      report_failure($sformatf("result %0d: %s expected %0d, got %0d",
                               results_seen, field, want_v, got_v));
  endfunction

  // Drop key valid if it is up. Track it ourselves, since a nonblocking
  // update made earlier in this step is not visible yet.
  task automatic key_idle();
    if (key_offered) begin
      key_if.valid <= 1'b0;
      key_offered = 1'b0;
    end
  endtask

  // Offer one key and wait for its transaction. Valid is left high so that
  // a following call in the same step keeps the channel busy without a dip;
  // callers that stop sending go through key_idle.
  task automatic send_key(input logic [KEY_W-1:0] k);
    int unsigned gap;
    gap = (tx_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      key_idle();
      repeat (gap) @(posedge clk);
    end
    key_if.valid    <= 1'b1;
    key_if.key_byte <= k;
    key_offered = 1'b1;
    @(posedge clk);
    while (key_if.ready !== 1'b1) @(posedge clk);
    pending_results.push_back(predict_key_result(k));
    if (!is_ignored(k)) active_keys++;
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic wait_drained();
    key_idle();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write both geometry registers back to back while the block is idle.
  task automatic set_geometry(input logic [CFG_DATA_W-1:0] col_val,
                              input logic [CFG_DATA_W-1:0] row_val);
    wait_drained();
    // Let a trailing row clear finish.
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= REG_COLUMNS;
    cfg_if.data  <= col_val;
    @(posedge clk);
    while (cfg_if.ready !== 1'b1) @(posedge clk);
    cols_reg = col_val[NC_W-1:0];
    cfg_if.index <= REG_ROWS;
    cfg_if.data  <= row_val;
    @(posedge clk);
    while (cfg_if.ready !== 1'b1) @(posedge clk);
    rows_reg = row_val[NR_W-1:0];
    cfg_if.valid <= 1'b0;
  endtask

  // ESC [ 3|4 digit m, now and then broken: a stray, missing or extra
  // character, a restart by ESC, or a CR / backspace in the middle.
  task automatic send_colour_sequence();
    logic [KEY_W-1:0] seq[$];
    int unsigned      pos;
    seq = '{K_ESC, CH_LBRACK, ($urandom_range(0, 1) ? CH_3 : CH_4),
            KEY_W'(CH_0 + $urandom_range(0, 9)), CH_M};
    pos = $urandom_range(1, 3);
    case ($urandom_range(0, 9))
      0: seq[pos] = KEY_W'($urandom_range(K_SPACE, K_LAST));
      1: seq.insert(pos, KEY_W'($urandom_range(0, 255)));
      2: seq.delete(pos);
      3: seq.insert(pos, K_ESC);
      4: seq.insert(pos, ($urandom_range(0, 1) ? K_CR : K_BS));
      default: ;
    endcase
    foreach (seq[i]) send_key(seq[i]);
  endtask

  // One step of typical traffic: mostly text, some line control, colour
  // sequences and noise bytes.
  task automatic send_mixed_key();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) send_key(KEY_W'($urandom_range(K_SPACE, K_LAST)));
    else if (pick < 63) send_key(K_CR);
    else if (pick < 70) send_key(K_BS);
    else if (pick < 85) send_colour_sequence();
    else send_key(KEY_W'($urandom_range(0, 255)));
  endtask

  // Directed keys at the default 40 x 30 geometry.
  task automatic test_directed_keys();
    logic [KEY_W-1:0] keys[$];
    keys = '{
      8'h00, 8'hFF, 8'h7F, 8'h80,          // ignored bytes
      K_BS,                                // backspace on an empty line
      K_SPACE, K_LAST, 8'h41,              // printable extremes and a letter
      K_BS,
      K_ESC, CH_LBRACK, CH_3, K_CR,        // CR leaves the sequence open
      K_ESC, CH_LBRACK, CH_4, CH_9, CH_M,  // restart, background 9 -> white
      K_ESC, CH_LBRACK, CH_3, CH_0 + 7'd1, CH_0 + 7'd2, CH_M, // fourth char dropped
      K_ESC, CH_LBRACK, CH_M               // too short, no effect
    };
    foreach (keys[i]) send_key(keys[i]);
    wait_drained();
  endtask

  // Walk through geometries, the out-of-range register values among them.
  task automatic test_screen_geometry();
    logic [CFG_DATA_W-1:0] col_list [7] = '{7'd0, 7'd1, 7'd127, 7'd64, 7'd65, 7'd3, 7'd40};
    logic [CFG_DATA_W-1:0] row_list [7] = '{7'd0, 7'd1, 7'h7F, 7'd32, 7'd33, 7'd2, 7'd30};
    foreach (col_list[i]) begin
      set_geometry(col_list[i], row_list[i]);
      repeat (40) send_mixed_key();
    end
    wait_drained();
  endtask

  // Push the top pointer and cursor far out, then shrink the screen under them.
  task automatic test_shrink_screen();
    set_geometry(7'd64, 7'd32);
    repeat (45) send_key(K_CR);
    repeat (50) send_key(KEY_W'($urandom_range(K_SPACE, K_LAST)));
    set_geometry(7'd5, 7'd3);
    repeat (20) send_mixed_key();
    wait_drained();
  endtask

  // Type past the line length limit, then back up a few characters.
  task automatic test_line_full();
    set_geometry(7'd64, 7'd32);
    repeat (LINE_MAX + 8) send_key(KEY_W'($urandom_range(K_SPACE, K_LAST)));
    repeat (4) send_key(K_BS);
    send_key(K_CR);
    wait_drained();
  endtask

  // Stall the result side for a long stretch while keys keep coming, so the
  // block fills up and holds its key input; then pause until all is back.
  task automatic test_backpressure();
    set_geometry(7'd4, 7'd3);
    tx_gaps = 1'b0;
    hold_off_request = HOLD_OFF_CYCLES;
    repeat (40) send_mixed_key();
    wait_drained();
    tx_gaps = 1'b1;
  endtask

  // Blocks of mixed traffic, each under its own geometry and idling mode.
  task automatic test_random_traffic();
    int unsigned block_end;
    logic [CFG_DATA_W-1:0] c_val;
    logic [CFG_DATA_W-1:0] r_val;
    block_end = active_keys;
    while (active_keys < block_end + RANDOM_KEYS) begin
      case ($urandom_range(0, 9))
        0: begin
          c_val = $urandom_range(0, 1) ? 7'd0 : 7'd127;
          r_val = $urandom_range(0, 1) ? 7'd0 : 7'h7F;
        end
        1, 2, 3: begin
          c_val = CFG_DATA_W'($urandom_range(1, 64));
          r_val = CFG_DATA_W'($urandom_range(1, 32));
        end
        default: begin
          c_val = CFG_DATA_W'($urandom_range(1, 10));
          r_val = CFG_DATA_W'($urandom_range(1, 6));
        end
      endcase
      set_geometry(c_val, r_val);
      tx_gaps   = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);
      repeat (60) send_mixed_key();
    end
    wait_drained();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
  endtask

  // Result side: random stalls, stretches without any, and the long
  // hold-off on request.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_request > 0) begin
        hold_left = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        if (rx_stalls && $urandom_range(0, 4) == 0) stall_left = pick_gap();
      end
    end
  end

  // Compare every result transaction with the oldest expectation.
  always @(posedge clk) begin : check_results
    result_t seen;
    result_t want;
    if (rst === 1'b0 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      seen.cell_write   = res_if.cell_write;
      seen.cell_address = res_if.cell_address;
      seen.cell_char    = res_if.cell_char;
      seen.cell_colour  = res_if.cell_colour;
      seen.cursor_col   = res_if.cursor_col;
      seen.cursor_row   = res_if.cursor_row;
      seen.top_row      = res_if.top_row;
      seen.fore_index   = res_if.fore_index;
      seen.back_index   = res_if.back_index;
      seen.line_done    = res_if.line_done;
      if (pending_results.size() == 0) begin
        report_failure($sformatf("result %0d arrived with none expected", results_seen));
      end else begin
        want = pending_results.pop_front();
        check_field("cell_write",   want.cell_write,   seen.cell_write);
        check_field("cell_address", want.cell_address, seen.cell_address);
        check_field("cell_char",    want.cell_char,    seen.cell_char);
        check_field("cell_colour",  want.cell_colour,  seen.cell_colour);
        check_field("cursor_col",   want.cursor_col,   seen.cursor_col);
        check_field("cursor_row",   want.cursor_row,   seen.cursor_row);
        check_field("top_row",      want.top_row,      seen.top_row);
        check_field("fore_index",   want.fore_index,   seen.fore_index);
        check_field("back_index",   want.back_index,   seen.back_index);
        check_field("line_done",    want.line_done,    seen.line_done);
        // Unknown bits never compare equal as integers; flag them as well.
        if ($isunknown(seen)) report_failure($sformatf("result %0d has unknown bits",
                                                       results_seen));
      end
      results_seen++;
    end
  end

  // Watchdog: count cycles and give up at the limit.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin : run_tests
    key_if.valid    = 1'b0;
    key_if.key_byte = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = REG_COLUMNS;
    cfg_if.data     = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_directed_keys();
    test_screen_geometry();
    test_shrink_screen();
    test_line_full();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    // Anything arriving late shows up here as an unexpected result.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("failures: %0d, results outstanding: %0d", fail_count,
               pending_results.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
